// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the detection row decoder
// Concurrent checks, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define DRD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define DRD_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/drd_pkg.sv -----
// ----------------------------------------------------------------------------
// drd_pkg
// Types and constants of the detection row decoder.
// ----------------------------------------------------------------------------
package drd_pkg;

	localparam int VALUE_W   = 24;
	localparam int CLASS_W   = 9;
	localparam int IDX_W     = 9;
	localparam int COUNT_W   = 8;
	localparam int SCORE_W   = 16;
	localparam int PAD_W     = 12;
	localparam int INV_W     = 24;
	localparam int INV_SPLIT = 12;
	localparam int FRAME_W   = 13;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int QUEUE_DEPTH = 2;

	// row element positions
	localparam logic [IDX_W-1:0] ELEM_CX  = 9'd0;
	localparam logic [IDX_W-1:0] ELEM_CY  = 9'd1;
	localparam logic [IDX_W-1:0] ELEM_W   = 9'd2;
	localparam logic [IDX_W-1:0] ELEM_H   = 9'd3;
	localparam logic [IDX_W-1:0] ELEM_OBJ = 9'd4;
	localparam logic [IDX_W-1:0] ELEM_CLS0 = 9'd5;

	localparam logic signed [CLASS_W-1:0] CLS_NONE = -9'sd1;

	// register reset values
	localparam logic [SCORE_W-1:0] RST_CONF_THRESHOLD = 16'd16384;
	localparam logic [COUNT_W-1:0] RST_CLASS_COUNT    = 8'd80;
	localparam logic [PAD_W-1:0]   RST_PAD            = 12'd0;
	localparam logic [INV_W-1:0]   RST_INVERSE_SCALE  = 24'd65536;
	localparam logic [FRAME_W-1:0] RST_FRAME          = 13'd640;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CONF_THRESHOLD = 3'd0,
		CFG_CLASS_COUNT    = 3'd1,
		CFG_PAD_LEFT       = 3'd2,
		CFG_PAD_TOP        = 3'd3,
		CFG_INVERSE_SCALE  = 3'd4,
		CFG_FRAME_WIDTH    = 3'd5,
		CFG_FRAME_HEIGHT   = 3'd6
	} drd_cfg_index_t;

	// settings seen by the box and score datapath
	typedef struct packed {
		logic [SCORE_W-1:0] conf_threshold;
		logic [PAD_W-1:0]   pad_left;
		logic [PAD_W-1:0]   pad_top;
		logic [INV_W-1:0]   inverse_scale;
		logic [FRAME_W-1:0] frame_width;
		logic [FRAME_W-1:0] frame_height;
	} drd_cfg_t;

	// one finished row, as handed from front to back
	typedef struct packed {
		logic signed [VALUE_W-1:0] cx;
		logic signed [VALUE_W-1:0] cy;
		logic signed [VALUE_W-1:0] bw;
		logic signed [VALUE_W-1:0] bh;
		logic signed [VALUE_W-1:0] obj;
		logic signed [VALUE_W-1:0] best;
		logic signed [CLASS_W-1:0] cls;
	} drd_row_t;

endpackage

// ----- rtl/detection_row_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// detection_row_decoder_unit
// Turns a streamed detection row into one scored, frame-space box.
// ----------------------------------------------------------------------------
// Input channel (in_valid, in_stall, value) takes one row element per
// transfer: centre x, centre y, width, height, objectness, then class_count
// class scores. One transfer per cycle is sustained; in_stall rises only
// when two finished rows are waiting for the box pipeline.
// On the last element of a row the row goes through the row queue to the box
// pipeline. Its result (out_valid, out_stall, class_index, score, box_*)
// shows after the pipeline registers, or never when the row is dropped on its
// score. The edge multipliers are split in two partial products.
// A stalled result is held in the output register and the pipeline stops;
// the row queue behind it fills and the collector runs until the queue is full.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and takes each write on cfg_valid; writes to an unused
// index are ignored. Settings are meant to change only while the block is
// idle. Reset restores the register defaults and restarts the row at its
// centre x element.
// ----------------------------------------------------------------------------
module detection_row_decoder_unit import drd_pkg::*; #(
	parameter int VALUE_FRAC_BITS = 12,
	parameter int COORD_BITS      = 12,
	parameter int MAX_CLASSES     = 255
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [VALUE_W-1:0]  value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [CLASS_W-1:0]  class_index,
	output logic [SCORE_W-1:0]         score,
	output logic [COORD_BITS-1:0]      box_left,
	output logic [COORD_BITS-1:0]      box_top,
	output logic [COORD_BITS-1:0]      box_width,
	output logic [COORD_BITS-1:0]      box_height,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	drd_cfg_t           cfg_q;
	logic [COUNT_W-1:0] class_count_q;

	logic     in_accept;
	logic     row_push, row_pop, q_full, q_not_empty;
	drd_row_t row_in, row_head;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.conf_threshold <= RST_CONF_THRESHOLD;
			class_count_q        <= RST_CLASS_COUNT;
			cfg_q.pad_left       <= RST_PAD;
			cfg_q.pad_top        <= RST_PAD;
			cfg_q.inverse_scale  <= RST_INVERSE_SCALE;
			cfg_q.frame_width    <= RST_FRAME;
			cfg_q.frame_height   <= RST_FRAME;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CONF_THRESHOLD: cfg_q.conf_threshold <= cfg_data[SCORE_W-1:0];
				CFG_CLASS_COUNT:    class_count_q        <= cfg_data[COUNT_W-1:0];
				CFG_PAD_LEFT:       cfg_q.pad_left       <= cfg_data[PAD_W-1:0];
				CFG_PAD_TOP:        cfg_q.pad_top        <= cfg_data[PAD_W-1:0];
				CFG_INVERSE_SCALE:  cfg_q.inverse_scale  <= cfg_data[INV_W-1:0];
				CFG_FRAME_WIDTH:    cfg_q.frame_width    <= cfg_data[FRAME_W-1:0];
				CFG_FRAME_HEIGHT:   cfg_q.frame_height   <= cfg_data[FRAME_W-1:0];
				default: ;
			endcase
		end
	end

	drd_front #(
		.MAX_CLASSES (MAX_CLASSES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.class_count (class_count_q),
		.accept      (in_accept),
		.value       (value),
		.row_push    (row_push),
		.row         (row_in)
	);

	drd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (row_push),
		.push_row  (row_in),
		.pop       (row_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (row_head)
	);

	drd_back #(
		.VALUE_FRAC_BITS (VALUE_FRAC_BITS),
		.COORD_BITS      (COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.row_valid   (q_not_empty),
		.row         (row_head),
		.row_pop     (row_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.class_index (class_index),
		.score       (score),
		.box_left    (box_left),
		.box_top     (box_top),
		.box_width   (box_width),
		.box_height  (box_height)
	);

endmodule

// ----- rtl/drd_front.sv -----
// ----------------------------------------------------------------------------
// drd_front
// Collects one prediction row element by element and tracks the best class.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module drd_front import drd_pkg::*; #(
	parameter int MAX_CLASSES = 255
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [COUNT_W-1:0]        class_count,
	input  logic                      accept,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      row_push,
	output drd_row_t                  row
);

	localparam int NC_CAP = (MAX_CLASSES > 255) ? 255 : MAX_CLASSES;

	logic [IDX_W-1:0]          idx_q;
	logic signed [VALUE_W-1:0] cx_q, cy_q, bw_q, bh_q, obj_q, best_q;
	logic signed [CLASS_W-1:0] best_cls_q;

	logic [COUNT_W-1:0] nc;
	logic [IDX_W:0]     idx_x;
	logic               is_cls, upd, row_end;

	assign nc    = (class_count > COUNT_W'(NC_CAP)) ? COUNT_W'(NC_CAP) : class_count;
	assign idx_x = {1'b0, idx_q};

	assign is_cls  = (idx_q >= ELEM_CLS0) &&
			(idx_x < ({2'b00, nc} + {1'b0, ELEM_CLS0}));
	assign upd     = is_cls && (value > best_q);
	// row closes on the last class element, or on objectness with no classes
	assign row_end = idx_x >= ({2'b00, nc} + {1'b0, ELEM_OBJ});

	always_comb begin
		row.cx   = cx_q;
		row.cy   = cy_q;
		row.bw   = bw_q;
		row.bh   = bh_q;
		row.obj  = (idx_q == ELEM_OBJ) ? value : obj_q;
		row.best = upd ? value : best_q;
		row.cls  = upd ? $signed(CLASS_W'(idx_q - ELEM_CLS0)) : best_cls_q;
	end

	assign row_push = accept && row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			best_q     <= '0;
			best_cls_q <= CLS_NONE;
		end else if (accept) begin
			if (row_end) begin
				idx_q      <= '0;
				best_q     <= '0;
				best_cls_q <= CLS_NONE;
			end else begin
				idx_q <= idx_q + 1'b1;
				if (upd) begin
					best_q     <= value;
					best_cls_q <= $signed(CLASS_W'(idx_q - ELEM_CLS0));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (idx_q)
				ELEM_CX:  cx_q  <= value;
				ELEM_CY:  cy_q  <= value;
				ELEM_W:   bw_q  <= value;
				ELEM_H:   bh_q  <= value;
				ELEM_OBJ: obj_q <= value;
				default: ;
			endcase
		end
	end

	`DRD_ASSERT(a_row_restart, clk, arst_n, (row_push |=> (idx_q == '0)), "row index not cleared after row end")
	`DRD_ASSERT(a_best_pairs, clk, arst_n, ((best_cls_q == CLS_NONE) == (best_q == '0)), "best class and best score disagree")

endmodule

// ----- rtl/drd_queue.sv -----
// ----------------------------------------------------------------------------
// drd_queue
// Short queue of finished rows between the row collector and the box maths.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module drd_queue import drd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  drd_row_t push_row,
	input  logic     pop,
	output logic     full,
	output logic     not_empty,
	output drd_row_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	drd_row_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_row;
	end

	`DRD_NEVER(a_no_overflow, clk, arst_n, (push && full && !pop), "row queue overflow")
	`DRD_NEVER(a_no_underflow, clk, arst_n, (pop && !not_empty), "row queue read while empty")

endmodule

// ----- rtl/drd_back.sv -----
// ----------------------------------------------------------------------------
// drd_back
// Score check and letterbox removal for one finished row, five stages deep.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module drd_back import drd_pkg::*; #(
	parameter int VALUE_FRAC_BITS = 12,
	parameter int COORD_BITS      = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  drd_cfg_t                     cfg,
	input  logic                         row_valid,
	input  drd_row_t                     row,
	output logic                         row_pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [CLASS_W-1:0]    class_index,
	output logic [SCORE_W-1:0]           score,
	output logic [COORD_BITS-1:0]        box_left,
	output logic [COORD_BITS-1:0]        box_top,
	output logic [COORD_BITS-1:0]        box_width,
	output logic [COORD_BITS-1:0]        box_height
);

	// term 2c +/- s - 2*pad, then times inverse scale
	localparam int TW   = (VALUE_FRAC_BITS + 15 > 27) ? VALUE_FRAC_BITS + 15 : 27;
	localparam int PPW  = TW + INV_SPLIT + 1;
	localparam int PW   = TW + INV_W + 1;
	localparam int SH   = VALUE_FRAC_BITS + 17;
	localparam int EW   = PW - SH;
	localparam int SSH  = 2 * VALUE_FRAC_BITS - 16;
	localparam int PRW  = 2 * VALUE_W;
	localparam int PADZ = TW - PAD_W - VALUE_FRAC_BITS - 1;
	localparam int IHW  = INV_W - INV_SPLIT;

	logic en;

	// stage 1
	logic                      s1_valid_q;
	logic signed [CLASS_W-1:0] cls_s1;
	logic signed [PRW-1:0]     prod_s1;
	logic signed [TW-1:0]      term_s1 [4];
	// stage 2
	logic                      s2_valid_q;
	logic signed [CLASS_W-1:0] cls_s2;
	logic                      keep_s2;
	logic [SCORE_W-1:0]        score_s2;
	logic signed [PPW-1:0]     pl_s2 [4];
	logic signed [PPW-1:0]     ph_s2 [4];
	// stage 3
	logic                      s3_valid_q;
	logic signed [CLASS_W-1:0] cls_s3;
	logic                      keep_s3;
	logic [SCORE_W-1:0]        score_s3;
	logic signed [PW-1:0]      full_s3 [4];
	// stage 4
	logic                      s4_valid_q;
	logic signed [CLASS_W-1:0] cls_s4;
	logic                      keep_s4;
	logic [SCORE_W-1:0]        score_s4;
	logic signed [EW-1:0]      near_s4 [2];
	logic signed [EW-1:0]      far_s4 [2];
	// output register
	logic                      out_valid_q;
	logic signed [CLASS_W-1:0] class_index_q;
	logic [SCORE_W-1:0]        score_q;
	logic [COORD_BITS-1:0]     near_q [2];
	logic [COORD_BITS-1:0]     ext_q [2];

	// comb
	logic signed [TW-1:0]      cen2 [2];
	logic signed [TW-1:0]      size [2];
	logic signed [TW-1:0]      pad2 [2];
	logic signed [TW-1:0]      term_d [4];
	logic signed [PRW-1:0]     sc;
	logic                      keep_d;
	logic [SCORE_W-1:0]        score_d;
	logic signed [INV_SPLIT:0] inv_lo;
	logic signed [IHW:0]       inv_hi;
	logic signed [PW-1:0]      pl_x, ph_x;
	logic signed [PW-1:0]      full_d [4];
	logic signed [PW-1:0]      rnd;
	logic signed [PW-1:0]      sh_lo, sh_hi;
	logic signed [EW-1:0]      lim [2];
	logic signed [EW-1:0]      near_d [2];
	logic signed [EW-1:0]      far_d [2];
	logic signed [EW:0]        ext_w [2];
	logic [COORD_BITS-1:0]     near_o [2];
	logic [COORD_BITS-1:0]     ext_o [2];

	// whole pipeline moves unless the output register is held
	assign en      = !(out_valid_q && out_stall);
	assign row_pop = en && row_valid;

	// stage 1: edge terms and the raw score product
	always_comb begin
		cen2[0] = $signed({{(TW - VALUE_W){row.cx[VALUE_W-1]}}, row.cx}) <<< 1;
		cen2[1] = $signed({{(TW - VALUE_W){row.cy[VALUE_W-1]}}, row.cy}) <<< 1;
		size[0] = $signed({{(TW - VALUE_W){row.bw[VALUE_W-1]}}, row.bw});
		size[1] = $signed({{(TW - VALUE_W){row.bh[VALUE_W-1]}}, row.bh});
		pad2[0] = $signed({{PADZ{1'b0}}, cfg.pad_left, {(VALUE_FRAC_BITS + 1){1'b0}}});
		pad2[1] = $signed({{PADZ{1'b0}}, cfg.pad_top, {(VALUE_FRAC_BITS + 1){1'b0}}});
		for (int a = 0; a < 2; a++) begin
			term_d[2*a]     = cen2[a] - size[a] - pad2[a];
			term_d[2*a + 1] = cen2[a] + size[a] - pad2[a];
		end
	end

	// stage 2: score decision, partial products of the edges
	always_comb begin
		sc      = prod_s1 >>> SSH;
		keep_d  = !prod_s1[PRW-1] &&
				((sc[PRW-1:SCORE_W] != '0) || (sc[SCORE_W-1:0] >= cfg.conf_threshold));
		score_d = (sc[PRW-1:SCORE_W] != '0) ? '1 : sc[SCORE_W-1:0];
		inv_lo  = $signed({1'b0, cfg.inverse_scale[INV_SPLIT-1:0]});
		inv_hi  = $signed({1'b0, cfg.inverse_scale[INV_W-1:INV_SPLIT]});
	end

	// stage 3: recombine partial products
	always_comb begin
		pl_x = '0;
		ph_x = '0;
		for (int i = 0; i < 4; i++) begin
			pl_x      = $signed({{(PW - PPW){pl_s2[i][PPW-1]}}, pl_s2[i]});
			ph_x      = $signed({{(PW - PPW){ph_s2[i][PPW-1]}}, ph_s2[i]});
			full_d[i] = (ph_x <<< INV_SPLIT) + pl_x;
		end
	end

	// stage 4: floor near edges, ceil far edges, clip to the frame
	always_comb begin
		rnd   = $signed({{(PW - SH){1'b0}}, {SH{1'b1}}});
		sh_lo = '0;
		sh_hi = '0;
		lim[0] = $signed({{(EW - FRAME_W){1'b0}}, cfg.frame_width}) - EW'(1);
		lim[1] = $signed({{(EW - FRAME_W){1'b0}}, cfg.frame_height}) - EW'(1);
		for (int a = 0; a < 2; a++) begin
			sh_lo     = full_s3[2*a] >>> SH;
			sh_hi     = (full_s3[2*a + 1] + rnd) >>> SH;
			near_d[a] = sh_lo[EW-1] ? '0 : sh_lo[EW-1:0];
			far_d[a]  = ($signed(sh_hi[EW-1:0]) > lim[a]) ? lim[a] : sh_hi[EW-1:0];
		end
	end

	// stage 5: extents and saturation to the coordinate range
	always_comb begin
		for (int a = 0; a < 2; a++) begin
			ext_w[a]  = {far_s4[a][EW-1], far_s4[a]} - {near_s4[a][EW-1], near_s4[a]};
			near_o[a] = (near_s4[a][EW-1:COORD_BITS] != '0) ? '1 :
					near_s4[a][COORD_BITS-1:0];
			if (ext_w[a][EW])
				ext_o[a] = '0;
			else if (ext_w[a][EW-1:COORD_BITS] != '0)
				ext_o[a] = '1;
			else
				ext_o[a] = ext_w[a][COORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			s3_valid_q  <= 1'b0;
			s4_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			s1_valid_q  <= row_valid;
			s2_valid_q  <= s1_valid_q;
			s3_valid_q  <= s2_valid_q;
			s4_valid_q  <= s3_valid_q;
			out_valid_q <= s4_valid_q && keep_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s1   <= row.cls;
			prod_s1  <= row.obj * row.best;
			cls_s2   <= cls_s1;
			keep_s2  <= keep_d;
			score_s2 <= score_d;
			cls_s3   <= cls_s2;
			keep_s3  <= keep_s2;
			score_s3 <= score_s2;
			cls_s4   <= cls_s3;
			keep_s4  <= keep_s3;
			score_s4 <= score_s3;
			class_index_q <= cls_s4;
			score_q       <= score_s4;
			for (int i = 0; i < 4; i++) begin
				term_s1[i] <= term_d[i];
				pl_s2[i]   <= term_s1[i] * inv_lo;
				ph_s2[i]   <= term_s1[i] * inv_hi;
				full_s3[i] <= full_d[i];
			end
			for (int a = 0; a < 2; a++) begin
				near_s4[a] <= near_d[a];
				far_s4[a]  <= far_d[a];
				near_q[a]  <= near_o[a];
				ext_q[a]   <= ext_o[a];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign class_index = class_index_q;
	assign score       = score_q;
	assign box_left    = near_q[0];
	assign box_top     = near_q[1];
	assign box_width   = ext_q[0];
	assign box_height  = ext_q[1];

	`DRD_ASSERT(a_no_class_no_score, clk, arst_n, ((out_valid_q && (class_index_q == CLS_NONE)) |-> (score_q == '0)), "score without a class")

endmodule
